FILE: hdl/med_pkg.sv
// shared types and constants of the multitap echo delay unit
`timescale 1ns / 1ps

package med_pkg;

   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 14;
   localparam int DELAY_BITS     = 16;
   localparam int TAP_REGS       = 4;
   localparam int TAP_HALF_BITS  = 32;
   localparam int TAP_CNT_BITS   = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_INPUT_GAIN = 3'd0,
      REG_TAP_COUNT  = 3'd1,
      REG_TAPS_0_1   = 3'd2,
      REG_TAPS_2_3   = 3'd3,
      REG_TAPS_4_5   = 3'd4,
      REG_TAPS_6_7   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctrl_type;

endpackage

FILE: hdl/med_if.sv
// sample channels of the multitap echo delay unit
`timescale 1ns / 1ps

interface med_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface med_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface

FILE: hdl/med_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module med_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/med_tap_mac.sv
// multiply-accumulate datapath with rounding and saturation
`timescale 1ns / 1ps

module med_tap_mac import med_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] op_sample,
   input  logic signed [GAIN_BITS-1:0]   op_gain,
   output logic                          busy,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
   localparam int ACC_W  = PROD_W + 4;
   localparam int SH_W   = ACC_W - GAIN_FRAC;
   localparam longint MAX_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [SH_W-1:0] MAX_V = SH_W'(MAX_L);
   localparam logic signed [SH_W-1:0] MIN_V = SH_W'(-MAX_L - 1);
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (GAIN_FRAC - 1));

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_v_ff;
   logic                     prod_first_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [SH_W-1:0]   shr;

   assign prod_in = op_sample * op_gain;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctrl.valid;
      end
      prod_ff       <= prod_in;
      prod_first_ff <= ctrl.first;
      if (prod_v_ff) begin
         if (prod_first_ff) begin
            acc_ff <= ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // round half up, then clamp to the sample range
   assign rnd  = acc_ff + HALF;
   assign shr  = rnd[ACC_W-1:GAIN_FRAC];
   assign busy = prod_v_ff;

   always_comb begin
      priority if (shr > MAX_V) begin
         result = MAX_V[SAMPLE_BITS-1:0];
      end else if (shr < MIN_V) begin
         result = MIN_V[SAMPLE_BITS-1:0];
      end else begin
         result = shr[SAMPLE_BITS-1:0];
      end
   end

endmodule

FILE: hdl/multitap_echo_delay_unit.sv
// top level of the multitap echo delay unit
//
//  channel   direction  handshake            payload
//  req_chan  in         valid/ready          in_sample
//  rsp_chan  out        valid/ready          out_sample
//  csr_*     in         csr_wr_en, no wait   csr_index, csr_wr_data
//
// with n active taps a transaction issues n tap reads in ISSUE, then ends in DRAIN
// (no ISSUE when no tap is active); the single read port of the delay store takes
// one tap per cycle. no clearing pass after reset: a fill count makes entries not
// yet written read as zero. a result waiting in the output register does not stop
// the next accept, only the end of that transaction's accumulation.
`timescale 1ns / 1ps

module multitap_echo_delay_unit import med_pkg::*; #(
   parameter int BUFFER_LENGTH = 2048,
   parameter int MAX_TAPS      = 8,
   parameter int SAMPLE_BITS   = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   med_req_if.sink                   req_chan,
   med_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int ADDR_W = $clog2(BUFFER_LENGTH);
   localparam int FILL_W = ADDR_W + 1;
   localparam logic [FILL_W-1:0]       DEPTH_F = FILL_W'(BUFFER_LENGTH);
   localparam logic [ADDR_W-1:0]       LAST_A  = ADDR_W'(BUFFER_LENGTH - 1);
   localparam logic [DELAY_BITS:0]     LAST_D  = (DELAY_BITS + 1)'(BUFFER_LENGTH - 1);
   localparam logic [TAP_CNT_BITS-1:0] MAX_N   = TAP_CNT_BITS'(MAX_TAPS);

   typedef enum logic [1:0] {IDLE, ISSUE, DRAIN} state_type;

   state_type                      state_ff;
   logic signed [GAIN_BITS-1:0]    input_gain_ff;
   logic [TAP_CNT_BITS-1:0]        tap_count_ff;
   logic [CSR_DATA_BITS-1:0]       tap_regs_ff [TAP_REGS];
   logic [ADDR_W-1:0]              wp_ff;
   logic [ADDR_W-1:0]              cur_w_ff;
   logic [FILL_W-1:0]              fill_ff;
   logic [TAP_CNT_BITS-1:0]        t_ff;
   logic [TAP_CNT_BITS-1:0]        n_ff;
   logic                           rd_v_ff;
   logic                           rd_ok_ff;
   logic signed [GAIN_BITS-1:0]    gain_d_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]  rsp_data_ff;

   logic                           req_accept;
   logic                           drain_go;
   logic [TAP_CNT_BITS-1:0]        n_now;
   logic [CSR_DATA_BITS-1:0]       tap_pair;
   logic [TAP_HALF_BITS-1:0]       tap_half;
   logic [DELAY_BITS-1:0]          delay_raw;
   logic [ADDR_W-1:0]              delay_c;
   logic [FILL_W-1:0]              diff;
   logic [FILL_W-1:0]              wrapped;
   logic [ADDR_W-1:0]              rd_addr;
   logic                           tap_ok;
   logic [SAMPLE_BITS-1:0]         ram_q;
   mac_ctrl_type                   mac_ctrl;
   logic signed [SAMPLE_BITS-1:0]  mac_sample;
   logic signed [GAIN_BITS-1:0]    mac_gain;
   logic                           mac_busy;
   logic signed [SAMPLE_BITS-1:0]  mac_result;

   assign req_chan.ready      = (state_ff == IDLE);
   assign req_accept          = req_chan.valid && (state_ff == IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_sample = rsp_data_ff;

   assign drain_go = (state_ff == DRAIN) && !rd_v_ff && !mac_busy
                     && (!rsp_valid_ff || rsp_chan.ready);

   assign n_now = (tap_count_ff > MAX_N) ? MAX_N : tap_count_ff;

   // tap slot decode and read address
   assign tap_pair  = tap_regs_ff[t_ff[2:1]];
   assign tap_half  = t_ff[0] ? tap_pair[2*TAP_HALF_BITS-1:TAP_HALF_BITS]
                              : tap_pair[TAP_HALF_BITS-1:0];
   assign delay_raw = tap_half[DELAY_BITS-1:0];
   assign delay_c   = ({1'b0, delay_raw} > LAST_D) ? LAST_A : delay_raw[ADDR_W-1:0];
   assign diff      = {1'b0, cur_w_ff} - {1'b0, delay_c};
   assign wrapped   = diff + DEPTH_F;
   assign rd_addr   = (cur_w_ff >= delay_c) ? diff[ADDR_W-1:0] : wrapped[ADDR_W-1:0];
   assign tap_ok    = ({1'b0, delay_c} < fill_ff);

   med_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (BUFFER_LENGTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wp_ff),
      .wr_data (req_chan.in_sample),
      .rd_en   (state_ff == ISSUE),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      mac_ctrl.valid = req_accept || rd_v_ff;
      mac_ctrl.first = req_accept;
      if (req_accept) begin
         mac_sample = req_chan.in_sample;
         mac_gain   = input_gain_ff;
      end else begin
         mac_sample = rd_ok_ff ? $signed(ram_q) : '0;
         mac_gain   = gain_d_ff;
      end
   end

   med_tap_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .op_sample (mac_sample),
      .op_gain   (mac_gain),
      .busy      (mac_busy),
      .result    (mac_result)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         input_gain_ff <= 16'sd16384;
         tap_count_ff  <= TAP_CNT_BITS'(8);
         for (int i = 0; i < TAP_REGS; i++) begin
            tap_regs_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_INPUT_GAIN: input_gain_ff   <= csr_wr_data[GAIN_BITS-1:0];
            REG_TAP_COUNT:  tap_count_ff    <= csr_wr_data[TAP_CNT_BITS-1:0];
            REG_TAPS_0_1:   tap_regs_ff[0]  <= csr_wr_data;
            REG_TAPS_2_3:   tap_regs_ff[1]  <= csr_wr_data;
            REG_TAPS_4_5:   tap_regs_ff[2]  <= csr_wr_data;
            REG_TAPS_6_7:   tap_regs_ff[3]  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         wp_ff        <= LAST_A;
         fill_ff      <= '0;
         t_ff         <= '0;
         n_ff         <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff <= (state_ff == ISSUE);
         if (drain_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_chan.valid) begin
                  cur_w_ff <= wp_ff;
                  wp_ff    <= (wp_ff == LAST_A) ? '0 : wp_ff + 1'b1;
                  fill_ff  <= (fill_ff == DEPTH_F) ? fill_ff : fill_ff + 1'b1;
                  n_ff     <= n_now;
                  t_ff     <= '0;
                  state_ff <= (n_now == '0) ? DRAIN : ISSUE;
               end
            end
            ISSUE: begin
               rd_ok_ff  <= tap_ok;
               gain_d_ff <= tap_half[TAP_HALF_BITS-1:DELAY_BITS];
               t_ff      <= t_ff + 1'b1;
               if (t_ff == n_ff - 1'b1) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (drain_go) begin
                  rsp_data_ff <= mac_result;
                  state_ff    <= IDLE;
               end
            end
         endcase
      end
   end

endmodule
